// ----- rtl/grid_local_minimum_detector_top_defines.svh -----
// Assertion macros shared by the grid local minimum detector RTL.
// Included by the modules that carry concurrent assertions.
`ifndef GRID_LOCAL_MINIMUM_DETECTOR_TOP_DEFINES_SVH
`define GRID_LOCAL_MINIMUM_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define GLMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GLMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/glmd_pkg.sv -----
// Package for the grid local minimum detector: sizes, register codes,
// payload types and the dimension clamp. No dependencies.
`default_nettype none

package glmd_pkg;

    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 128;
    localparam int HEIGHT_BITS   = 4;
    localparam int COL_BITS      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int POS_OUT_BITS  = 7;
    localparam int RISK_BITS     = 19;
    localparam int CFG_DATA_BITS = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int NUM_CAND      = 3;
    localparam int CAND_IDX_BITS = $clog2(NUM_CAND);

    typedef logic [HEIGHT_BITS-1:0]   t_height;
    typedef logic [COL_BITS-1:0]      t_col;
    typedef logic [ROW_BITS-1:0]      t_row;
    typedef logic [POS_OUT_BITS-1:0]  t_pos_out;
    typedef logic [RISK_BITS-1:0]     t_risk;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CAND_IDX_BITS-1:0] t_cand_idx;

    localparam t_cfg_idx CFG_GRID_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_GRID_HEIGHT = t_cfg_idx'(1);

    // one column of the row buffer: row r-1 and row r-2
    typedef struct packed {
        t_height up1;
        t_height up2;
    } t_col_pair;

    typedef struct packed {
        t_row    row;
        t_col    col;
        t_height height;
        t_height ctr;
        t_height up2;
        t_height left1;
        t_height prev1;
        t_height prev2;
        logic    has_r1;
        logic    has_r2;
        logic    has_c1;
        logic    has_c2;
        logic    has_right;
        logic    last_row;
        logic    final_cell;
    } t_judge_item;

    typedef struct packed {
        t_row    row;
        t_col    col;
        t_height height;
    } t_cand;

    typedef struct packed {
        logic [NUM_CAND-1:0]  hit;
        t_cand [NUM_CAND-1:0] cand;
        logic                 frame_done;
    } t_batch;

    typedef struct packed {
        t_pos_out min_row;
        t_pos_out min_col;
        t_height  min_height;
        t_risk    risk_total;
        logic     last;
        logic     frame_done;
    } t_result;

    function automatic int clamp_dim_m1(input t_cfg_data v, input int max_dim);
        int d;
        d = int'(v);
        if (d == 0) begin
            d = 1;
        end
        if (d > max_dim) begin
            d = max_dim;
        end
        return d - 1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/glmd_if.sv -----
// Stream interfaces for the grid local minimum detector: height requests in,
// minimum requests out. Depends on glmd_pkg.
`default_nettype none

interface glmd_in_if;
    import glmd_pkg::*;

    logic    valid;
    logic    ready;
    t_height height;

    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

interface glmd_out_if;
    import glmd_pkg::*;

    logic     valid;
    logic     ready;
    t_pos_out min_row;
    t_pos_out min_col;
    t_height  min_height;
    t_risk    risk_total;
    logic     last;
    logic     frame_done;

    modport source (output valid, output min_row, output min_col, output min_height,
                    output risk_total, output last, output frame_done, input ready);
    modport sink   (input valid, input min_row, input min_col, input min_height,
                    input risk_total, input last, input frame_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/glmd_row_mem.sv -----
// Row buffer RAM: one entry per column holding the two previous rows.
// One write and one registered read per cycle, write data forwarded. Uses glmd_pkg.
`default_nettype none

module glmd_row_mem (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  glmd_pkg::t_col       i_waddr,
    input  glmd_pkg::t_col_pair  i_wdata,
    input  logic                 i_re,
    input  glmd_pkg::t_col       i_raddr,
    output glmd_pkg::t_col_pair  o_rdata
);
    import glmd_pkg::*;

    t_col_pair mem [MAX_WIDTH];
    t_col_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/glmd_judge.sv -----
// Judge stage: holds one accepted cell with its neighborhood and evaluates
// the up to three minimum candidates it settles. Uses glmd_pkg.
`default_nettype none

module glmd_judge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  glmd_pkg::t_judge_item i_item,
    input  glmd_pkg::t_height     i_right,
    output logic                  o_ready,
    output logic                  o_batch_valid,
    output glmd_pkg::t_batch      o_batch,
    input  logic                  i_take
);
    import glmd_pkg::*;

    logic        r_valid;
    t_judge_item r_item;
    logic        hit_up;
    logic        hit_cur;
    logic        hit_self;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    // cell above, previous cell on the last row, and the final cell itself
    always_comb begin
        hit_up = r_item.has_r1
            && (!r_item.has_r2 || (r_item.up2 > r_item.ctr))
            && (r_item.height > r_item.ctr)
            && (!r_item.has_c1 || (r_item.left1 > r_item.ctr))
            && (!r_item.has_right || (i_right > r_item.ctr));
        hit_cur = r_item.last_row && r_item.has_c1
            && (!r_item.has_r1 || (r_item.left1 > r_item.prev1))
            && (!r_item.has_c2 || (r_item.prev2 > r_item.prev1))
            && (r_item.height > r_item.prev1);
        hit_self = r_item.final_cell
            && (!r_item.has_r1 || (r_item.ctr > r_item.height))
            && (!r_item.has_c1 || (r_item.prev1 > r_item.height));
    end

    always_comb begin
        o_batch.hit           = {hit_self, hit_cur, hit_up};
        o_batch.cand[0].row    = r_item.row - t_row'(1);
        o_batch.cand[0].col    = r_item.col;
        o_batch.cand[0].height = r_item.ctr;
        o_batch.cand[1].row    = r_item.row;
        o_batch.cand[1].col    = r_item.col - t_col'(1);
        o_batch.cand[1].height = r_item.prev1;
        o_batch.cand[2].row    = r_item.row;
        o_batch.cand[2].col    = r_item.col;
        o_batch.cand[2].height = r_item.height;
        o_batch.frame_done     = r_item.final_cell;
    end

    assign o_batch_valid = r_valid;
    assign o_ready       = !r_valid || i_take;

endmodule

`default_nettype wire

// ----- rtl/glmd_emit.sv -----
// Result emitter: serializes each cell's found minima, keeps the running
// risk sum and drives the output register. Uses glmd_pkg and the defines header.
`default_nettype none

`include "grid_local_minimum_detector_top_defines.svh"

module glmd_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_batch_valid,
    input  glmd_pkg::t_batch i_batch,
    output logic             o_take,
    glmd_out_if.source       o_out_chan
);
    import glmd_pkg::*;

    logic [NUM_CAND-1:0] r_pend;
    logic [NUM_CAND-1:0] rem;
    t_batch              r_batch;
    t_risk               r_risk;
    t_risk               sum;
    logic                r_out_valid;
    t_result             r_out;
    t_cand_idx           sel_idx;
    t_cand               sel;
    logic                out_free;
    logic                emit_go;
    logic                load_ok;

    always_comb begin
        if (r_pend[0]) begin
            sel_idx = t_cand_idx'(0);
        end else if (r_pend[1]) begin
            sel_idx = t_cand_idx'(1);
        end else begin
            sel_idx = t_cand_idx'(2);
        end
        rem          = r_pend;
        rem[sel_idx] = 1'b0;
    end

    assign sel      = r_batch.cand[sel_idx];
    assign sum      = r_risk + t_risk'(sel.height) + t_risk'(1);
    assign out_free = !r_out_valid || o_out_chan.ready;
    assign emit_go  = out_free && (r_pend != '0);
    assign load_ok  = (r_pend == '0) || (emit_go && (rem == '0));
    assign o_take   = i_batch_valid && load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_risk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_pend <= i_batch.hit;
            end else if (emit_go) begin
                r_pend <= rem;
            end
            // drop the sum at a restart or once the final cell's minima are out
            if (i_clear) begin
                r_risk <= '0;
            end else if (o_take && i_batch.frame_done && (i_batch.hit == '0)) begin
                r_risk <= '0;
            end else if (emit_go && (rem == '0) && r_batch.frame_done) begin
                r_risk <= '0;
            end else if (emit_go) begin
                r_risk <= sum;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out_chan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_batch <= i_batch;
        end
        if (emit_go) begin
            r_out.min_row    <= t_pos_out'(sel.row);
            r_out.min_col    <= t_pos_out'(sel.col);
            r_out.min_height <= sel.height;
            r_out.risk_total <= sum;
            r_out.last       <= (rem == '0);
            r_out.frame_done <= r_batch.frame_done;
        end
    end

    assign o_out_chan.valid      = r_out_valid;
    assign o_out_chan.min_row    = r_out.min_row;
    assign o_out_chan.min_col    = r_out.min_col;
    assign o_out_chan.min_height = r_out.min_height;
    assign o_out_chan.risk_total = r_out.risk_total;
    assign o_out_chan.last       = r_out.last;
    assign o_out_chan.frame_done = r_out.frame_done;

    `GLMD_ASSERT_NEXT(a_risk_frame_clear, i_clk, i_rst_n, emit_go && (rem == '0) && r_batch.frame_done, r_risk == '0, "risk sum not cleared after frame end")
    `GLMD_ASSERT_IMPL(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid), $past(emit_go), "output valid rose without an emission")
    `GLMD_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, emit_go && (rem != '0), (r_pend != '0) && r_out_valid, "pending minima lost mid burst")

endmodule

`default_nettype wire

// ----- rtl/grid_local_minimum_detector_top.sv -----
// Grid local minimum detector top level: position counters, configuration,
// row buffer read-modify-write and the judge and emit stages. Uses glmd_pkg,
// glmd_if, glmd_row_mem, glmd_judge, glmd_emit and the defines header.
//
//   channel      dir  request
//   i_in_chan    in   one height, raster order
//   o_out_chan   out  one local minimum with running risk sum
//   i_cfg_*      in   register write, no handshake
//
// One height per cycle while the judge stage has room; a cell reporting several
// minima holds its successor in the emitter, which moves one minimum per cycle
// through the output register unless the output stalls. Each height does one
// read-modify-write of its column in the row buffer RAM, next column read ahead.
// Reset clears position, risk sum and valid flags; the RAM needs no clearing.
// A stalled output fills the emitter and then the judge stage before ready drops.
`default_nettype none

`include "grid_local_minimum_detector_top_defines.svh"

module grid_local_minimum_detector_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  glmd_pkg::t_cfg_idx  i_cfg_idx,
    input  glmd_pkg::t_cfg_data i_cfg_wdata,
    glmd_in_if.sink             i_in_chan,
    glmd_out_if.source          o_out_chan
);
    import glmd_pkg::*;

    t_col        r_w_m1;
    t_row        r_h_m1;
    t_row        r_row;
    t_col        r_col;
    t_row        n_row;
    t_col        n_col;
    t_height     r_prev1;
    t_height     r_prev2;
    t_height     r_prev_up;
    logic        acc;
    logic        at_row_end;
    logic        at_last_row;
    logic        final_cell;
    logic        cfg_hit;
    t_col_pair   rd;
    t_col_pair   wdata;
    t_col        raddr;
    t_judge_item item;
    logic        judge_ready;
    logic        batch_valid;
    t_batch      batch;
    logic        batch_take;

    assign acc         = i_in_chan.valid && judge_ready;
    assign at_row_end  = (r_col == r_w_m1);
    assign at_last_row = (r_row == r_h_m1);
    assign final_cell  = at_row_end && at_last_row;
    assign cfg_hit     = i_cfg_we && ((i_cfg_idx == CFG_GRID_WIDTH)
                                   || (i_cfg_idx == CFG_GRID_HEIGHT));

    always_comb begin
        if (final_cell) begin
            n_row = '0;
            n_col = '0;
        end else if (at_row_end) begin
            n_row = r_row + t_row'(1);
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + t_col'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1 <= t_col'(MAX_WIDTH - 1);
            r_h_m1 <= t_row'(MAX_HEIGHT - 1);
            r_row  <= '0;
            r_col  <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_idx == CFG_GRID_WIDTH) begin
                r_w_m1 <= t_col'(clamp_dim_m1(i_cfg_wdata, MAX_WIDTH));
            end else begin
                r_h_m1 <= t_row'(clamp_dim_m1(i_cfg_wdata, MAX_HEIGHT));
            end
            r_row <= '0;
            r_col <= '0;
        end else if (acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // left-hand window: current row c-1, c-2 and previous row c-1
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_prev2   <= r_prev1;
            r_prev1   <= i_in_chan.height;
            r_prev_up <= rd.up1;
        end
    end

    assign raddr     = at_row_end ? '0 : (r_col + t_col'(1));
    assign wdata.up1 = i_in_chan.height;
    assign wdata.up2 = rd.up1;

    glmd_row_mem u_row_mem (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (r_col),
        .i_wdata (wdata),
        .i_re    (acc),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    always_comb begin
        item.row        = r_row;
        item.col        = r_col;
        item.height     = i_in_chan.height;
        item.ctr        = rd.up1;
        item.up2        = rd.up2;
        item.left1      = r_prev_up;
        item.prev1      = r_prev1;
        item.prev2      = r_prev2;
        item.has_r1     = (r_row != '0);
        item.has_r2     = (r_row != '0) && (r_row != t_row'(1));
        item.has_c1     = (r_col != '0);
        item.has_c2     = (r_col != '0) && (r_col != t_col'(1));
        item.has_right  = !at_row_end;
        item.last_row   = at_last_row;
        item.final_cell = final_cell;
    end

    glmd_judge u_judge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (acc),
        .i_item        (item),
        .i_right       (rd.up1),
        .o_ready       (judge_ready),
        .o_batch_valid (batch_valid),
        .o_batch       (batch),
        .i_take        (batch_take)
    );

    glmd_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (cfg_hit),
        .i_batch_valid (batch_valid),
        .i_batch       (batch),
        .o_take        (batch_take),
        .o_out_chan    (o_out_chan)
    );

    assign i_in_chan.ready = judge_ready;

    `GLMD_ASSERT_IMPL(a_pos_in_grid, i_clk, i_rst_n, 1'b1, (r_col <= r_w_m1) && (r_row <= r_h_m1), "position outside the grid")
    `GLMD_ASSERT_NEXT(a_final_wraps, i_clk, i_rst_n, acc && final_cell && !cfg_hit, (r_row == '0) && (r_col == '0), "position did not wrap after final cell")
    `GLMD_ASSERT_NEXT(a_row_advance, i_clk, i_rst_n, acc && at_row_end && !final_cell && !cfg_hit, (r_col == '0) && (r_row == ($past(r_row) + t_row'(1))), "row did not advance at row end")

endmodule

`default_nettype wire

// ----- test/grid_local_minimum_detector_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for grid_local_minimum_detector_top: streams height maps under random stalls
// and checks every reported minimum against a built-in raster-order predictor.
// Depends on glmd_pkg, glmd_if and the detector RTL.

module grid_local_minimum_detector_top_tb;
    import glmd_pkg::*;

    localparam int STALL_LIMIT   = 400;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 380;
    localparam int MAX_AREA      = 260;
    localparam int MAX_PHASE     = 300;

    typedef enum {FILL_UNIFORM, FILL_NARROW, FILL_EXTREME} t_fill;

    class minima_scoreboard;
        t_height   line_buf [2*MAX_WIDTH];
        int        row_pos;
        int        col_pos;
        t_risk     risk_acc;
        t_cfg_data width_reg;
        t_cfg_data height_reg;
        t_result   expected_minima [$];
        int        errors;

        function new();
            row_pos    = 0;
            col_pos    = 0;
            risk_acc   = '0;
            width_reg  = 8'd128;
            height_reg = 8'd128;
            errors     = 0;
            foreach (line_buf[i]) line_buf[i] = '0;
        endfunction

        static function int grid_dim(t_cfg_data value, int max_dim);
            int d;
            d = int'(value);
            if (d == 0) d = 1;
            if (d > max_dim) d = max_dim;
            return d;
        endfunction

        function int pending();
            return expected_minima.size();
        endfunction

        // a width or height write restarts the frame; the line buffer is kept
        function void write_reg(t_cfg_idx idx, t_cfg_data value);
            if (idx == CFG_GRID_WIDTH) begin
                width_reg = value;
            end else if (idx == CFG_GRID_HEIGHT) begin
                height_reg = value;
            end else begin
                return;
            end
            row_pos  = 0;
            col_pos  = 0;
            risk_acc = '0;
        endfunction

        function void push_minimum(int r, int c, t_height h, bit done);
            t_result m;
            risk_acc     = risk_acc + t_risk'(h) + t_risk'(1);
            m.min_row    = t_pos_out'(r);
            m.min_col    = t_pos_out'(c);
            m.min_height = h;
            m.risk_total = risk_acc;
            m.last       = 1'b0;
            m.frame_done = done;
            expected_minima.insert(expected_minima.size(), m);
        endfunction

        function void note_request(t_height h);
            int      w;
            int      hg;
            int      r;
            int      c;
            int      now_base;
            int      prev_base;
            int      found;
            bit      final_cell;
            bit      ok;
            t_height ctr;
            w  = grid_dim(width_reg, MAX_WIDTH);
            hg = grid_dim(height_reg, MAX_HEIGHT);
            if (row_pos >= hg || col_pos >= w) begin
                row_pos = 0;
                col_pos = 0;
            end
            r          = row_pos;
            c          = col_pos;
            now_base   = (r % 2) * MAX_WIDTH;
            prev_base  = ((r + 1) % 2) * MAX_WIDTH;
            final_cell = (r == hg - 1) && (c == w - 1);
            found      = expected_minima.size();
            // judge the cell above the incoming one
            if (r >= 1) begin
                ctr = line_buf[prev_base + c];
                ok  = (r < 2 || line_buf[now_base + c] > ctr) && (h > ctr)
                      && (c < 1 || line_buf[prev_base + c - 1] > ctr)
                      && (c + 1 >= w || line_buf[prev_base + c + 1] > ctr);
                if (ok) push_minimum(r - 1, c, ctr, final_cell);
            end
            line_buf[now_base + c] = h;
            // last row: judge the cell to the left
            if (r == hg - 1 && c >= 1) begin
                ctr = line_buf[now_base + c - 1];
                ok  = (r < 1 || line_buf[prev_base + c - 1] > ctr)
                      && (c < 2 || line_buf[now_base + c - 2] > ctr) && (h > ctr);
                if (ok) push_minimum(r, c - 1, ctr, final_cell);
            end
            if (final_cell) begin
                ok = (r < 1 || line_buf[prev_base + c] > h)
                     && (c < 1 || line_buf[now_base + c - 1] > h);
                if (ok) push_minimum(r, c, h, 1'b1);
            end
            if (expected_minima.size() > found) begin
                expected_minima[expected_minima.size() - 1].last = 1'b1;
            end
            if (final_cell) begin
                row_pos  = 0;
                col_pos  = 0;
                risk_acc = '0;
            end else if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_minima.size() == 0) begin
                $error("unexpected minimum at row %0d col %0d", got.min_row, got.min_col);
                errors++;
                return;
            end
            want = expected_minima.pop_front();
            compare_field("min_row", 32'(want.min_row), 32'(got.min_row));
            compare_field("min_col", 32'(want.min_col), 32'(got.min_col));
            compare_field("min_height", 32'(want.min_height), 32'(got.min_height));
            compare_field("risk_total", 32'(want.risk_total), 32'(got.risk_total));
            compare_field("last", 32'(want.last), 32'(got.last));
            compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_wdata;

    glmd_in_if  in_chan ();
    glmd_out_if out_chan ();

    minima_scoreboard tracker;
    bit               in_steady;
    bit               out_steady;
    int               idle_cycles = 0;

    grid_local_minimum_detector_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_chan   (in_chan),
        .o_out_chan  (out_chan)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (out_chan.valid && out_chan.ready) begin
                got.min_row    = out_chan.min_row;
                got.min_col    = out_chan.min_col;
                got.min_height = out_chan.min_height;
                got.risk_total = out_chan.risk_total;
                got.last       = out_chan.last;
                got.frame_done = out_chan.frame_done;
                tracker.check_result(got);
            end
            if (in_chan.valid && in_chan.ready) begin
                tracker.note_request(in_chan.height);
            end
            if ((out_chan.valid && out_chan.ready) || (in_chan.valid && in_chan.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        out_chan.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = out_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_chan.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_chan.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_chan.valid) @(posedge i_clk);
        end
    end

    function automatic t_cfg_data pick_dim();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return t_cfg_data'($urandom_range(129, 255));
            2:       return t_cfg_data'($urandom_range(9, 128));
            default: return t_cfg_data'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic send_height(input t_height h);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_chan.valid  <= 1'b1;
        in_chan.height <= h;
        @(posedge i_clk);
        while (!in_chan.ready) @(posedge i_clk);
    endtask

    // drop valid, drain expected minima, then let the pipeline empty
    task automatic settle();
        in_chan.valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_grid(input bit set_w, input t_cfg_data w,
                                input bit set_h, input t_cfg_data h);
        if (set_w) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_GRID_WIDTH;
            i_cfg_wdata <= w;
            @(posedge i_clk);
            tracker.write_reg(CFG_GRID_WIDTH, w);
        end
        if (set_h) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_GRID_HEIGHT;
            i_cfg_wdata <= h;
            @(posedge i_clk);
            tracker.write_reg(CFG_GRID_HEIGHT, h);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_height   pat3x3 [9];
        t_height   pat2x2 [4];
        t_height   pat_row [4];
        t_height   level;
        t_height   base;
        t_cfg_data w_val;
        t_cfg_data h_val;
        t_fill     fill;
        bit        set_w;
        bit        set_h;
        int        pick;
        int        sent;
        int        phase;
        int        area;
        int        count;

        pat3x3          = '{4'd5, 4'd1, 4'd5, 4'd2, 4'd9, 4'd0, 4'd15, 4'd3, 4'd15};
        pat2x2          = '{4'd7, 4'd3, 4'd3, 4'd7};
        pat_row         = '{4'd15, 4'd0, 4'd15, 4'd0};
        tracker         = new();
        in_steady       = 1'b0;
        out_steady      = 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_GRID_WIDTH;
        i_cfg_wdata    <= '0;
        in_chan.valid  <= 1'b0;
        in_chan.height <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero width acts as one: two 1x1 frames
        program_grid(1'b1, 8'd0, 1'b1, 8'd1);
        send_height(4'd0);
        send_height(4'd15);
        settle();

        program_grid(1'b1, 8'd3, 1'b1, 8'd3);
        foreach (pat3x3[i]) send_height(pat3x3[i]);
        settle();

        // partial frame, then a height-only write restarts it
        program_grid(1'b1, 8'd2, 1'b1, 8'd2);
        send_height(pat2x2[0]);
        send_height(pat2x2[1]);
        settle();
        program_grid(1'b0, 8'd0, 1'b1, 8'd2);
        foreach (pat2x2[i]) send_height(pat2x2[i]);
        settle();

        program_grid(1'b1, 8'd4, 1'b1, 8'd1);
        foreach (pat_row[i]) send_height(pat_row[i]);
        settle();

        program_grid(1'b1, 8'd1, 1'b1, 8'd4);
        repeat (4) send_height(4'd8);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            set_w = 1'b1;
            set_h = 1'b1;
            if (phase == 0) begin
                w_val = 8'd255;
                h_val = 8'd1;
            end else if (phase == 1) begin
                w_val = 8'd1;
                h_val = 8'd255;
            end else begin
                w_val = pick_dim();
                h_val = pick_dim();
                if (minima_scoreboard::grid_dim(w_val, MAX_WIDTH)
                    * minima_scoreboard::grid_dim(h_val, MAX_HEIGHT) > MAX_AREA) begin
                    h_val = t_cfg_data'($urandom_range(1, 2));
                end
                pick  = $urandom_range(0, 2);
                set_w = (pick != 2);
                set_h = (pick != 1);
            end
            program_grid(set_w, w_val, set_h, h_val);

            area = minima_scoreboard::grid_dim(tracker.width_reg, MAX_WIDTH)
                   * minima_scoreboard::grid_dim(tracker.height_reg, MAX_HEIGHT);
            count = (area <= 40) ? area * $urandom_range(1, 3) : area;
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area);
            if (count > MAX_PHASE) count = MAX_PHASE;
            if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;

            fill       = t_fill'($urandom_range(0, 2));
            base       = t_height'($urandom_range(0, 13));
            in_steady  = ($urandom_range(0, 4) == 0);
            out_steady = ($urandom_range(0, 4) == 0);

            repeat (count) begin
                case (fill)
                    FILL_UNIFORM: level = t_height'($urandom_range(0, 15));
                    FILL_NARROW:  level = base + t_height'($urandom_range(0, 2));
                    default:      level = $urandom_range(0, 1) ? 4'hF : 4'h0;
                endcase
                send_height(level);
                sent++;
            end
            settle();
            phase++;
        end

        if (tracker.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/glmd_pkg.sv
rtl/glmd_if.sv
rtl/glmd_row_mem.sv
rtl/glmd_judge.sv
rtl/glmd_emit.sv
rtl/grid_local_minimum_detector_top.sv
test/grid_local_minimum_detector_top_tb.sv
